### src/mtuc_pkg.sv
// Shared types, constants and MD5 tables for the Merkle tree update and compare unit.
`default_nettype none
package mtuc_pkg;

	localparam int LEVELS_DEF = 4;
	localparam int HASH_W     = 128;

	// result status codes
	localparam logic [1:0] STAT_BYTE = 2'd0;
	localparam logic [1:0] STAT_LEAF = 2'd1;
	localparam logic [1:0] STAT_CMP  = 2'd2;
	localparam logic [1:0] STAT_ERR  = 2'd3;

	// configuration register indexes
	localparam logic REG_USED  = 1'b0;
	localparam logic REG_BYTES = 1'b1;

	localparam logic [3:0]  USED_RST  = 4'd8;
	localparam logic [15:0] BYTES_RST = 16'd1024;

	// chaining words, word 0 in the lowest bits
	localparam logic [HASH_W-1:0] MD5_INIT =
		{32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [1:0] {CORE_IDLE, CORE_INIT, CORE_START, CORE_START_INIT} core_op_t;
	typedef enum logic [2:0] {BUF_HOLD, BUF_BYTE, BUF_PAD, BUF_LEN, BUF_CLRLEN,
		BUF_PAIR} buf_op_t;
	typedef enum logic {RD_PATH, RD_CMP} rd_op_t;
	typedef enum logic [1:0] {WR_NONE, WR_LEAF, WR_DIG, WR_COPY} wr_op_t;
	typedef enum logic [2:0] {NODE_HOLD, NODE_ROOT, NODE_LEAFPAR, NODE_UP, NODE_LEFT,
		NODE_NEXT} node_op_t;

	// controller to datapath
	typedef struct packed {
		logic       in_take;
		logic       byte_step;
		core_op_t   core_op;
		buf_op_t    buf_op;
		rd_op_t     rd_op;
		wr_op_t     wr_op;
		node_op_t   node_op;
		logic       stream_done;
		logic       res_wr;
		logic [1:0] res_status;
		logic       res_leaf;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_cmp;
		logic bad;
		logic chunk_full;
		logic done_now;
		logic done_q;
		logic pad_two;
		logic pair_ok;
		logic copy_ok;
		logic node_top;
		logic node_odd;
		logic node_leaf;
		logic differ;
		logic core_busy;
		logic out_free;
	} sts_t;

	// message word used by round r
	function automatic logic [3:0] md5_word_idx(input logic [5:0] r);
		logic [3:0] g;
		unique case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

### src/mtuc_md5.sv
// MD5 compression engine, one round per cycle, holding the chaining words.
`default_nettype none
module mtuc_md5 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mtuc_pkg::core_op_t          core_op,
	input  wire logic [31:0]                 msg_word,
	output logic [3:0]                       msg_idx,
	output logic                             busy,
	output logic [mtuc_pkg::HASH_W-1:0]      digest
);

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic [mtuc_pkg::HASH_W-1:0] dig_q;

	logic [31:0] f, t, rot, nb;
	logic [63:0] rot_w;
	logic [4:0]  s;

	// round function
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		s     = mtuc_pkg::MD5_S[{rnd_q[5:4], rnd_q[1:0]}];
		t     = a_q + f + mtuc_pkg::MD5_K[rnd_q] + msg_word;
		rot_w = {t, t} << s;
		rot   = rot_w[63:32];
		nb    = b_q + rot;
	end

	assign msg_idx = mtuc_pkg::md5_word_idx(rnd_q);
	assign busy    = busy_q;
	assign digest  = dig_q;

	// sequence rounds and fold the result into the chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			dig_q  <= mtuc_pkg::MD5_INIT;
		end else begin
			unique case (core_op)
				mtuc_pkg::CORE_INIT: dig_q <= mtuc_pkg::MD5_INIT;
				mtuc_pkg::CORE_START: begin
					busy_q <= 1'b1;
					rnd_q  <= '0;
				end
				mtuc_pkg::CORE_START_INIT: begin
					dig_q  <= mtuc_pkg::MD5_INIT;
					busy_q <= 1'b1;
					rnd_q  <= '0;
				end
				default: begin
					if (busy_q) begin
						rnd_q <= rnd_q + 6'd1;
						if (rnd_q == 6'd63) begin
							busy_q        <= 1'b0;
							dig_q[31:0]   <= dig_q[31:0]   + d_q;
							dig_q[63:32]  <= dig_q[63:32]  + nb;
							dig_q[95:64]  <= dig_q[95:64]  + b_q;
							dig_q[127:96] <= dig_q[127:96] + c_q;
						end
					end
				end
			endcase
		end
	end

	// working words
	always_ff @(posedge clk) begin
		if (core_op == mtuc_pkg::CORE_START) begin
			a_q <= dig_q[31:0];
			b_q <= dig_q[63:32];
			c_q <= dig_q[95:64];
			d_q <= dig_q[127:96];
		end else if (core_op == mtuc_pkg::CORE_START_INIT) begin
			a_q <= mtuc_pkg::MD5_INIT[31:0];
			b_q <= mtuc_pkg::MD5_INIT[63:32];
			c_q <= mtuc_pkg::MD5_INIT[95:64];
			d_q <= mtuc_pkg::MD5_INIT[127:96];
		end else if (busy_q) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= nb;
		end
	end

endmodule
`default_nettype wire

### src/mtuc_dp.sv
// Datapath: input and config registers, message buffer, node store, walk index, result.
`default_nettype none
module mtuc_dp #(
	parameter int LEVELS = mtuc_pkg::LEVELS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mtuc_pkg::cmd_t cmd,
	output mtuc_pkg::sts_t      sts,
	input  wire logic           s_tvalid,
	input  wire logic [15:0]    s_tdata,
	input  wire logic [1:0]     s_tuser,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [7:0]          m_tdata,
	output logic [1:0]          m_tuser,
	input  wire logic           cfg_we,
	input  wire logic           cfg_addr,
	input  wire logic [15:0]    cfg_data
);

	localparam int H          = LEVELS;
	localparam int NODES      = 1 << H;
	localparam int LEAF_BASE  = 1 << (H - 1);
	localparam int AW         = H + 1;
	localparam int EW         = (H > 4) ? H : 4;
	localparam int HW         = mtuc_pkg::HASH_W;

	logic         func_q, tsel_q;
	logic [3:0]   blk_q;
	logic [7:0]   byte_q;
	logic [3:0]   used_q;
	logic [15:0]  bb_q;
	logic [16:0]  cnt_q;
	logic [3:0]   cur_q;
	logic         curt_q, done_q;
	logic [H-1:0] node_q;
	logic [31:0]  buf_q [16];
	logic [HW-1:0] mem [2*NODES];
	logic [HW-1:0] rd0_q, rd1_q;
	logic [2*NODES-1:0] vld_q;
	logic [1:0]   pend_status_q, out_status_q;
	logic [3:0]   pend_diff_q, out_diff_q;
	logic         out_valid_q;

	logic [EW-1:0] used_eff, leaf_w, last_w, diff_w;
	logic [H-1:0]  leaf_idx, last_idx, l_idx, r_idx;
	logic          restart, vl, vr;
	logic [16:0]   cnt_eff, cnt_new;
	logic [5:0]    pos, q;
	logic [AW-1:0] ra0, ra1, wa;
	logic [HW-1:0] wd, dig, h0, h1;
	logic [31:0]   len_word, msg_word;
	logic [3:0]    msg_idx, leaf_no;
	logic          core_busy;
	mtuc_pkg::core_op_t core_op;

	// stream bookkeeping and node addressing
	always_comb begin
		used_eff = (EW'(used_q) > EW'(LEAF_BASE)) ? EW'(LEAF_BASE) : EW'(used_q);
		restart  = (cnt_q != 17'd0) && ((blk_q != cur_q) || (tsel_q != curt_q));
		cnt_eff  = restart ? 17'd0 : cnt_q;
		cnt_new  = cnt_eff + 17'd1;
		pos      = cnt_eff[5:0];
		q        = cnt_q[5:0];
		len_word = {12'd0, cnt_q, 3'd0};
		leaf_w   = EW'(LEAF_BASE) + EW'(blk_q) - EW'(1);
		leaf_idx = leaf_w[H-1:0];
		last_w   = EW'(LEAF_BASE) + used_eff - EW'(1);
		last_idx = last_w[H-1:0];
		diff_w   = EW'(node_q) - EW'(LEAF_BASE) + EW'(1);
		leaf_no  = diff_w[3:0];
		l_idx    = {node_q[H-2:0], 1'b0};
		r_idx    = {node_q[H-2:0], 1'b1};
		unique case (cmd.rd_op)
			mtuc_pkg::RD_CMP: begin
				ra0 = {1'b0, node_q};
				ra1 = {1'b1, node_q};
			end
			default: begin
				ra0 = {tsel_q, l_idx};
				ra1 = {tsel_q, r_idx};
			end
		endcase
		vl = vld_q[ra0];
		vr = vld_q[ra1];
		h0 = vl ? rd0_q : '0;
		h1 = vr ? rd1_q : '0;
		unique case (cmd.wr_op)
			mtuc_pkg::WR_LEAF: begin
				wa = {tsel_q, leaf_idx};
				wd = dig;
			end
			mtuc_pkg::WR_COPY: begin
				wa = {tsel_q, node_q};
				wd = rd0_q;
			end
			default: begin
				wa = {tsel_q, node_q};
				wd = dig;
			end
		endcase
		core_op = (cmd.byte_step && restart) ? mtuc_pkg::CORE_INIT : cmd.core_op;
		if (cmd.stream_done) begin
			core_op = mtuc_pkg::CORE_INIT;
		end
	end

	// status towards the controller
	always_comb begin
		sts.is_cmp     = func_q;
		sts.bad        = (blk_q == 4'd0) || (EW'(blk_q) > used_eff);
		sts.chunk_full = (pos == 6'd63);
		sts.done_now   = (cnt_new >= {1'b0, bb_q});
		sts.done_q     = done_q;
		sts.pad_two    = (q >= 6'd56);
		sts.pair_ok    = (r_idx <= last_idx) && vl && vr;
		sts.copy_ok    = (l_idx <= last_idx) && vl;
		sts.node_top   = (node_q == H'(1));
		sts.node_odd   = node_q[0];
		sts.node_leaf  = node_q[H-1];
		sts.differ     = (h0 != h1);
		sts.core_busy  = core_busy;
		sts.out_free   = !out_valid_q || m_tready;
	end

	assign msg_word = buf_q[msg_idx];

	mtuc_md5 u_md5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.core_op  (core_op),
		.msg_word (msg_word),
		.msg_idx  (msg_idx),
		.busy     (core_busy),
		.digest   (dig)
	);

	// capture the accepted transfer
	always_ff @(posedge clk) begin
		if (cmd.in_take && s_tvalid) begin
			func_q <= s_tuser[0];
			tsel_q <= s_tuser[1];
			blk_q  <= s_tdata[3:0];
			byte_q <= s_tdata[11:4];
		end
	end

	// configuration and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= mtuc_pkg::USED_RST;
			bb_q   <= mtuc_pkg::BYTES_RST;
			cnt_q  <= '0;
			cur_q  <= '0;
			curt_q <= 1'b0;
			done_q <= 1'b0;
			node_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == mtuc_pkg::REG_USED) begin
					used_q <= cfg_data[3:0];
				end else begin
					bb_q <= cfg_data;
				end
			end
			if (cmd.byte_step) begin
				cnt_q  <= cnt_new;
				done_q <= sts.done_now;
				if (cnt_eff == 17'd0) begin
					cur_q  <= blk_q;
					curt_q <= tsel_q;
				end
			end else if (cmd.stream_done) begin
				cnt_q <= '0;
			end
			unique case (cmd.node_op)
				mtuc_pkg::NODE_ROOT:    node_q <= H'(1);
				mtuc_pkg::NODE_LEAFPAR: node_q <= leaf_idx >> 1;
				mtuc_pkg::NODE_UP:      node_q <= node_q >> 1;
				mtuc_pkg::NODE_LEFT:    node_q <= l_idx;
				mtuc_pkg::NODE_NEXT:    node_q <= node_q + H'(1);
				default:                node_q <= node_q;
			endcase
		end
	end

	// message buffer: bytes, padding, length and child pairs
	always_ff @(posedge clk) begin
		unique case (cmd.buf_op)
			mtuc_pkg::BUF_BYTE: buf_q[pos[5:2]][8*pos[1:0] +: 8] <= byte_q;
			mtuc_pkg::BUF_PAD: begin
				for (int p = 0; p < 64; p++) begin
					if (6'(p) == q) begin
						buf_q[p/4][8*(p%4) +: 8] <= 8'h80;
					end else if (6'(p) > q) begin
						buf_q[p/4][8*(p%4) +: 8] <= 8'h00;
					end
				end
			end
			mtuc_pkg::BUF_LEN: begin
				buf_q[14] <= len_word;
				buf_q[15] <= 32'd0;
			end
			mtuc_pkg::BUF_CLRLEN: begin
				for (int w = 0; w < 14; w++) begin
					buf_q[w] <= 32'd0;
				end
				buf_q[14] <= len_word;
				buf_q[15] <= 32'd0;
			end
			mtuc_pkg::BUF_PAIR: begin
				for (int w = 0; w < 4; w++) begin
					buf_q[w]     <= rd0_q[32*w +: 32];
					buf_q[w + 4] <= rd1_q[32*w +: 32];
				end
				for (int w = 8; w < 16; w++) begin
					buf_q[w] <= 32'd0;
				end
				buf_q[8]  <= 32'h80;
				buf_q[14] <= 32'd256;
			end
			default: begin
			end
		endcase
	end

	// node hash store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (cmd.wr_op != mtuc_pkg::WR_NONE) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	// node valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr_op != mtuc_pkg::WR_NONE) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			pend_status_q <= cmd.res_status;
			pend_diff_q   <= cmd.res_leaf ? leaf_no : 4'd0;
		end
		if (cmd.out_load) begin
			out_status_q <= pend_status_q;
			out_diff_q   <= pend_diff_q;
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_diff_q};
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

### src/mtuc_ctrl.sv
// Controller state machine sequencing bytes, leaf finish, path rehash and compare walk.
`default_nettype none
module mtuc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire mtuc_pkg::sts_t sts,
	output mtuc_pkg::cmd_t      cmd
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_RESP   = 5'd1;
	localparam logic [4:0] ST_BYTE   = 5'd2;
	localparam logic [4:0] ST_CHUNKW = 5'd3;
	localparam logic [4:0] ST_PAD    = 5'd4;
	localparam logic [4:0] ST_PADW   = 5'd5;
	localparam logic [4:0] ST_CLRLEN = 5'd6;
	localparam logic [4:0] ST_LEN    = 5'd7;
	localparam logic [4:0] ST_LENW   = 5'd8;
	localparam logic [4:0] ST_LEAF   = 5'd9;
	localparam logic [4:0] ST_PRD    = 5'd10;
	localparam logic [4:0] ST_PDEC   = 5'd11;
	localparam logic [4:0] ST_PWAIT  = 5'd12;
	localparam logic [4:0] ST_PWR    = 5'd13;
	localparam logic [4:0] ST_CRD    = 5'd14;
	localparam logic [4:0] ST_CCMP   = 5'd15;
	localparam logic [4:0] ST_CUP    = 5'd16;

	logic [4:0] state_q, state_d;

	always_comb begin
		cmd            = '0;
		cmd.core_op    = mtuc_pkg::CORE_IDLE;
		cmd.buf_op     = mtuc_pkg::BUF_HOLD;
		cmd.rd_op      = mtuc_pkg::RD_PATH;
		cmd.wr_op      = mtuc_pkg::WR_NONE;
		cmd.node_op    = mtuc_pkg::NODE_HOLD;
		cmd.res_status = mtuc_pkg::STAT_BYTE;
		state_d        = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_take = 1'b1;
				if (s_tvalid) begin
					state_d = ST_BYTE;
				end
			end
			// hand the result over and take the next transfer at once
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.in_take  = 1'b1;
					state_d      = s_tvalid ? ST_BYTE : ST_IDLE;
				end
			end
			ST_BYTE: begin
				priority if (sts.is_cmp) begin
					cmd.node_op = mtuc_pkg::NODE_ROOT;
					state_d     = ST_CRD;
				end else if (sts.bad) begin
					cmd.res_wr     = 1'b1;
					cmd.res_status = mtuc_pkg::STAT_ERR;
					state_d        = ST_RESP;
				end else begin
					cmd.byte_step = 1'b1;
					cmd.buf_op    = mtuc_pkg::BUF_BYTE;
					priority if (sts.chunk_full) begin
						cmd.core_op = mtuc_pkg::CORE_START;
						state_d     = ST_CHUNKW;
					end else if (sts.done_now) begin
						state_d = ST_PAD;
					end else begin
						cmd.res_wr = 1'b1;
						state_d    = ST_RESP;
					end
				end
			end
			ST_CHUNKW: begin
				if (!sts.core_busy) begin
					if (sts.done_q) begin
						state_d = ST_PAD;
					end else begin
						cmd.res_wr = 1'b1;
						state_d    = ST_RESP;
					end
				end
			end
			// close the block: padding, optional extra chunk, length chunk
			ST_PAD: begin
				cmd.buf_op = mtuc_pkg::BUF_PAD;
				if (sts.pad_two) begin
					cmd.core_op = mtuc_pkg::CORE_START;
					state_d     = ST_PADW;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_PADW: begin
				if (!sts.core_busy) begin
					state_d = ST_CLRLEN;
				end
			end
			ST_CLRLEN: begin
				cmd.buf_op  = mtuc_pkg::BUF_CLRLEN;
				cmd.core_op = mtuc_pkg::CORE_START;
				state_d     = ST_LENW;
			end
			ST_LEN: begin
				cmd.buf_op  = mtuc_pkg::BUF_LEN;
				cmd.core_op = mtuc_pkg::CORE_START;
				state_d     = ST_LENW;
			end
			ST_LENW: begin
				if (!sts.core_busy) begin
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: begin
				cmd.wr_op   = mtuc_pkg::WR_LEAF;
				cmd.node_op = mtuc_pkg::NODE_LEAFPAR;
				state_d     = ST_PRD;
			end
			// rehash the path one ancestor at a time
			ST_PRD: begin
				state_d = ST_PDEC;
			end
			ST_PDEC: begin
				if (sts.pair_ok) begin
					cmd.buf_op  = mtuc_pkg::BUF_PAIR;
					cmd.core_op = mtuc_pkg::CORE_START_INIT;
					state_d     = ST_PWAIT;
				end else begin
					if (sts.copy_ok) begin
						cmd.wr_op = mtuc_pkg::WR_COPY;
					end
					cmd.node_op = mtuc_pkg::NODE_UP;
					if (sts.node_top) begin
						cmd.stream_done = 1'b1;
						cmd.res_wr      = 1'b1;
						cmd.res_status  = mtuc_pkg::STAT_LEAF;
						state_d         = ST_RESP;
					end else begin
						state_d = ST_PRD;
					end
				end
			end
			ST_PWAIT: begin
				if (!sts.core_busy) begin
					state_d = ST_PWR;
				end
			end
			ST_PWR: begin
				cmd.wr_op   = mtuc_pkg::WR_DIG;
				cmd.node_op = mtuc_pkg::NODE_UP;
				if (sts.node_top) begin
					cmd.stream_done = 1'b1;
					cmd.res_wr      = 1'b1;
					cmd.res_status  = mtuc_pkg::STAT_LEAF;
					state_d         = ST_RESP;
				end else begin
					state_d = ST_PRD;
				end
			end
			// depth-first walk for the leftmost differing leaf
			ST_CRD: begin
				cmd.rd_op = mtuc_pkg::RD_CMP;
				state_d   = ST_CCMP;
			end
			ST_CCMP: begin
				cmd.rd_op = mtuc_pkg::RD_CMP;
				priority if (sts.differ && sts.node_leaf) begin
					cmd.res_wr     = 1'b1;
					cmd.res_status = mtuc_pkg::STAT_CMP;
					cmd.res_leaf   = 1'b1;
					state_d        = ST_RESP;
				end else if (sts.differ) begin
					cmd.node_op = mtuc_pkg::NODE_LEFT;
					state_d     = ST_CRD;
				end else begin
					state_d = ST_CUP;
				end
			end
			ST_CUP: begin
				cmd.rd_op = mtuc_pkg::RD_CMP;
				priority if (sts.node_top) begin
					cmd.res_wr     = 1'b1;
					cmd.res_status = mtuc_pkg::STAT_CMP;
					state_d        = ST_RESP;
				end else if (sts.node_odd) begin
					cmd.node_op = mtuc_pkg::NODE_UP;
				end else begin
					cmd.node_op = mtuc_pkg::NODE_NEXT;
					state_d     = ST_CRD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### src/merkle_tree_update_compare_unit.sv
// Top level of the Merkle tree update and compare unit.
//
// Two heap-indexed MD5 hash trees. Input transfers on s_*: a data byte for a
// one-based leaf block of tree 0 or 1, or a compare request. Every input gives
// one result on m_*: byte taken, leaf and path rehashed, compare done with the
// leftmost differing leaf (0 when equal), or error for a bad block number.
// A plain byte passes the byte state, and its result is loaded into the
// output register in the same cycle as the next transfer is taken. A byte
// that fills a 64-byte chunk waits for the one-round-per-cycle MD5 engine;
// the last byte of a block adds one or two chunk compressions and then, per
// ancestor, a read and a decision to copy, skip or hash the pair (shared engine).
// A compare reads and compares each node visited, backtracking in an up step.
// Results sit in an output register; the next input is taken in the same
// cycle the waiting result leaves, and nothing is lost while m_tready is low.
// Reset clears the valid bits of every node and the stream counters, loads the
// MD5 initial chaining words, and restores used_blocks to 8 and block_bytes to 1024.
// Configuration is written through cfg_we/cfg_addr/cfg_data while idle.
`default_nettype none
module merkle_tree_update_compare_unit #(
	parameter int LEVELS = mtuc_pkg::LEVELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // block_number[3:0], data_byte[11:4]
	input  wire logic [1:0]  s_tuser,   // func[0], tree_sel[1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // diff_block[3:0]
	output logic [1:0]       m_tuser,   // status[1:0]
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_data
);

	mtuc_pkg::cmd_t cmd;
	mtuc_pkg::sts_t sts;

	mtuc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtuc_dp #(
		.LEVELS (LEVELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	assign s_tready = cmd.in_take;

	// no new transfer while a compression is running
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sts.core_busy)
		else $error("input taken while MD5 engine busy");

	// a compression is only started on an idle engine
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.core_op == mtuc_pkg::CORE_START || cmd.core_op == mtuc_pkg::CORE_START_INIT)
		|-> !sts.core_busy)
		else $error("compression started on a busy engine");

	// the output register is only loaded when its previous result has gone
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire

### tb/tb_merkle_tree_update_compare_unit.sv
// Self-checking testbench for the Merkle tree update and compare unit.
`default_nettype none
module tb_merkle_tree_update_compare_unit;

	// MD5 round constants and rotations
	localparam logic [31:0] RK [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int RS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
	localparam logic [127:0] IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam int LEAF0 = 8;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] diff_block;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [15:0] cfg_data = '0;

	merkle_tree_update_compare_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// predictor state
	logic [3:0]   mdl_used = 4'd8;
	logic [15:0]  mdl_bytes = 16'd1024;
	logic [127:0] tree_hash [2][16];
	bit           tree_valid [2][16];
	logic [127:0] chain;
	logic [511:0] chunk;
	int           taken;
	int           cur_leaf;
	int           cur_tree;

	result_t pending_results [$];
	int      mismatches = 0;
	int      hold_cycles = 0;
	bit      calm = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [127:0] md5_chunk(input logic [127:0] st, input logic [511:0] w);
		logic [31:0] a, b, c, d, f, t;
		int g, s;
		a = st[31:0]; b = st[63:32]; c = st[95:64]; d = st[127:96];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				f = (b & c) | (~b & d); g = r;
			end else if (r < 32) begin
				f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
			end else if (r < 48) begin
				f = b ^ c ^ d; g = (3 * r + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * r) % 16;
			end
			s = RS[((r >> 4) << 2) | (r & 3)];
			t = a + f + RK[r] + w[32*g +: 32];
			a = d; d = c; c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		return {st[127:96] + d, st[95:64] + c, st[63:32] + b, st[31:0] + a};
	endfunction

	function automatic logic [127:0] md5_of_pair(input logic [127:0] l, input logic [127:0] r);
		logic [511:0] w;
		w = '0;
		w[127:0] = l;
		w[255:128] = r;
		w[263:256] = 8'h80;
		w[479:448] = 32'd256;
		return md5_chunk(IV, w);
	endfunction

	function automatic bit nodes_differ(input int i);
		logic [127:0] a, b;
		a = tree_valid[0][i] ? tree_hash[0][i] : '0;
		b = tree_valid[1][i] ? tree_hash[1][i] : '0;
		return a != b;
	endfunction

	function automatic logic [3:0] leftmost_diff(input int i);
		logic [3:0] res;
		if (i >= 16 || !nodes_differ(i)) return 4'd0;
		if (2 * i >= 16) return 4'(i - LEAF0 + 1);
		res = leftmost_diff(2 * i);
		if (res != 0) return res;
		return leftmost_diff(2 * i + 1);
	endfunction

	// close the running block into its leaf and rehash the path
	task automatic finish_leaf(input int t, input int blk, input int used);
		int q, i, l, last;
		logic [63:0] bits;
		q = taken % 64;
		bits = 64'(taken) * 8;
		chunk[8*q +: 8] = 8'h80;
		for (int p = q + 1; p < 64; p++) chunk[8*p +: 8] = 8'h00;
		if (q >= 56) begin
			chain = md5_chunk(chain, chunk);
			chunk = '0;
		end
		chunk[479:448] = bits[31:0];
		chunk[511:480] = bits[63:32];
		chain = md5_chunk(chain, chunk);
		i = LEAF0 + blk - 1;
		tree_hash[t][i] = chain;
		tree_valid[t][i] = 1'b1;
		last = LEAF0 + used - 1;
		for (i = i >> 1; i > 0; i = i >> 1) begin
			l = 2 * i;
			if (l + 1 <= last && tree_valid[t][l] && tree_valid[t][l+1]) begin
				tree_hash[t][i] = md5_of_pair(tree_hash[t][l], tree_hash[t][l+1]);
				tree_valid[t][i] = 1'b1;
			end else if (l <= last && tree_valid[t][l]) begin
				tree_hash[t][i] = tree_hash[t][l];
				tree_valid[t][i] = 1'b1;
			end
		end
		chain = IV;
		taken = 0;
	endtask

	// work out the result of one input transfer
	task automatic predict_tree_op(input bit func, input bit tsel, input int blk, input int b,
		output result_t res);
		int used;
		used = mdl_used > LEAF0 ? LEAF0 : mdl_used;
		res = '0;
		if (func) begin
			res.status = mtuc_pkg::STAT_CMP;
			res.diff_block = leftmost_diff(1);
		end else if (blk == 0 || blk > used) begin
			res.status = mtuc_pkg::STAT_ERR;
		end else begin
			if (taken != 0 && (blk != cur_leaf || tsel != cur_tree)) begin
				chain = IV;
				taken = 0;
			end
			if (taken == 0) begin
				cur_leaf = blk;
				cur_tree = tsel;
			end
			chunk[8*(taken % 64) +: 8] = 8'(b);
			if (taken % 64 == 63) chain = md5_chunk(chain, chunk);
			taken = (taken + 1) % 65536;
			res.status = mtuc_pkg::STAT_BYTE;
			if (taken == 0 || taken >= mdl_bytes) begin
				if (taken == 0) taken = 65536;
				finish_leaf(tsel, blk, used);
				res.status = mtuc_pkg::STAT_LEAF;
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// offer one item and hold it until the transfer
	task automatic send_tree_op(input bit func, input bit tsel, input int blk, input int b);
		int gap;
		result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'h0, 8'(b), 4'(blk)};
		s_tuser <= {tsel, func};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tree_op(func, tsel, blk, b, res);
		pending_results.push_back(res);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= 16'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (addr == mtuc_pkg::REG_USED) mdl_used = value[3:0];
		else mdl_bytes = value[15:0];
	endtask

	task automatic send_block(input bit tsel, input int blk, input int len, input int seed);
		for (int k = 0; k < len; k++)
			send_tree_op(1'b0, tsel, blk, seed >= 0 ? (seed + 7 * k) % 256 : $urandom_range(255));
	endtask

	// reset values, bad block numbers, compare of empty trees
	task automatic test_reset_state();
		send_tree_op(1'b1, 1'b0, 0, 0);
		send_tree_op(1'b0, 1'b0, 0, 8'hff);
		send_tree_op(1'b0, 1'b1, 9, 8'h00);
		send_tree_op(1'b0, 1'b1, 15, 8'hff);
		send_tree_op(1'b1, 1'b1, 15, 8'hff);
	endtask

	// one-byte leaves, field extremes, matching and differing trees
	task automatic test_single_byte_leaves();
		write_reg(mtuc_pkg::REG_BYTES, 1);
		send_tree_op(1'b0, 1'b0, 1, 8'h00);
		send_tree_op(1'b0, 1'b0, 8, 8'hff);
		send_tree_op(1'b1, 1'b0, 0, 0);
		send_tree_op(1'b0, 1'b1, 1, 8'h00);
		send_tree_op(1'b0, 1'b1, 8, 8'hff);
		send_tree_op(1'b1, 1'b0, 0, 0);
		send_tree_op(1'b0, 1'b1, 3, 8'h5a);
		send_tree_op(1'b1, 1'b0, 0, 0);
		// zero block size behaves as one
		write_reg(mtuc_pkg::REG_BYTES, 0);
		send_tree_op(1'b0, 1'b0, 3, 8'h5a);
		send_tree_op(1'b1, 1'b0, 0, 0);
	endtask

	// used_blocks at zero, one and above the leaf count
	task automatic test_used_blocks();
		write_reg(mtuc_pkg::REG_USED, 0);
		send_tree_op(1'b0, 1'b0, 1, 8'h11);
		write_reg(mtuc_pkg::REG_USED, 1);
		send_tree_op(1'b0, 1'b0, 1, 8'h22);
		send_tree_op(1'b0, 1'b0, 2, 8'h22);
		send_tree_op(1'b1, 1'b0, 0, 0);
		write_reg(mtuc_pkg::REG_USED, 15);
		send_tree_op(1'b0, 1'b1, 8, 8'h33);
		send_tree_op(1'b0, 1'b1, 9, 8'h33);
		send_tree_op(1'b1, 1'b0, 0, 0);
	endtask

	// padding edges, stream switch, shrinking a block mid-stream, largest size
	task automatic test_padding_and_switch();
		write_reg(mtuc_pkg::REG_BYTES, 56);
		send_block(1'b0, 2, 56, 3);
		write_reg(mtuc_pkg::REG_BYTES, 64);
		send_block(1'b1, 2, 64, 3);
		write_reg(mtuc_pkg::REG_BYTES, 65);
		send_block(1'b0, 4, 20, 9);
		send_block(1'b1, 4, 10, 9);
		send_block(1'b1, 5, 65, -1);
		send_block(1'b0, 6, 30, 1);
		write_reg(mtuc_pkg::REG_BYTES, 10);
		send_tree_op(1'b0, 1'b0, 6, 8'h44);
		write_reg(mtuc_pkg::REG_BYTES, 65535);
		send_block(1'b0, 7, 70, -1);
		send_tree_op(1'b1, 1'b0, 0, 0);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		write_reg(mtuc_pkg::REG_USED, 8);
		write_reg(mtuc_pkg::REG_BYTES, 3);
		hold_cycles = 400;
		for (int k = 0; k < 40; k++)
			send_tree_op(k % 9 == 8, 1'(k / 3), 1 + (k / 3) % 8, $urandom_range(255));
	endtask

	// random settings, mostly whole blocks with some noise and cut blocks
	task automatic test_random_streams();
		int sent, len, blk, r;
		bit t;
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 4 == 3);
			write_reg(mtuc_pkg::REG_USED, ph == 0 ? 8 : $urandom_range(15));
			r = $urandom_range(99);
			write_reg(mtuc_pkg::REG_BYTES, r < 70 ? $urandom_range(8, 1) :
				r < 95 ? $urandom_range(70, 55) : $urandom_range(200, 100));
			sent = 0;
			while (sent < 160) begin
				r = $urandom_range(99);
				if (r < 12) begin
					send_tree_op(1'b1, 1'($urandom), $urandom_range(15), $urandom_range(255));
					sent++;
				end else if (r < 20) begin
					send_tree_op(1'b0, 1'($urandom), $urandom_range(15), $urandom_range(255));
					sent++;
				end else begin
					t = 1'($urandom);
					blk = $urandom_range(mdl_used > 8 ? 8 : (mdl_used == 0 ? 1 : mdl_used), 1);
					len = mdl_bytes == 0 ? 1 : mdl_bytes;
					if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
					// shared seed makes both trees agree often
					send_block(t, blk, len, $urandom_range(1) ? blk * 13 : -1);
					sent += len;
				end
			end
		end
		calm = 1'b0;
	endtask

	// receiver: forced hold, then random stalls
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(99) < 25)
					stall = $urandom_range(99) < 90 ? $urandom_range(3, 1) : $urandom_range(50, 10);
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d diff_block %0d", m_tuser, m_tdata[3:0]);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status || m_tdata !== {4'h0, want.diff_block}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d diff_block %0d, got status %0d data %0h",
							want.status, want.diff_block, m_tuser, m_tdata);
				end
			end
		end
	end

	initial begin
		for (int t = 0; t < 2; t++)
			for (int i = 0; i < 16; i++) tree_valid[t][i] = 1'b0;
		chain = IV;
		chunk = '0;
		taken = 0;
		cur_leaf = 0;
		cur_tree = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_single_byte_leaves();
		test_used_blocks();
		test_padding_and_switch();
		test_backpressure();
		test_random_streams();
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("merkle_tree_update_compare_unit regression: pass");
		end else begin
			$display("merkle_tree_update_compare_unit regression: fail");
		end
		$finish;
	end

	// hard stop
	initial begin
		#100000000;
		$display("merkle_tree_update_compare_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
src/mtuc_pkg.sv
src/mtuc_md5.sv
src/mtuc_dp.sv
src/mtuc_ctrl.sv
src/merkle_tree_update_compare_unit.sv
tb/tb_merkle_tree_update_compare_unit.sv
